>>> sv/assert_macros.svh
// Assertion macros shared by the matcher RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/lobm_pkg.sv
// Package for the limit order book matcher: sequencer states, status codes, and request kind and side constants.
// Depends on nothing.
package lobm_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    STS_TRADE     = 3'd0,
    STS_RESTED    = 3'd1,
    STS_DONE      = 3'd2,
    STS_DUPLICATE = 3'd3,
    STS_FULL      = 3'd4,
    STS_CANCELLED = 3'd5,
    STS_NOT_FOUND = 3'd6
  } status_e;

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_CANCEL = 1'b1;
  localparam logic SIDE_BUY    = 1'b0;
  localparam logic SIDE_SELL   = 1'b1;

endpackage

>>> sv/limit_order_book_matcher.sv
// Price-time priority limit order book matcher, top level.
// Depends on lobm_pkg and assert_macros.svh.
//
// Requests (add or cancel) arrive as beats on the input channel; results
// leave as beats on the output channel, one register deep. Each request
// gives zero or more trade beats followed by one status beat with last set.
// The resting orders sit in a table of DEPTH entries held in small memories
// with a registered read port; only the valid bits are flip-flops.
// Every decision comes from one sequential pass over the table, one entry
// a cycle, feeding a single compare unit that tracks id match, first free
// slot and best crossing order. Each result beat is offered once a full
// pass and the decision after it are done, starting when the request or
// the previous trade beat is taken; the next request is accepted only
// after the status beat is taken, so receiver stalls add to that time.
// A trade that leaves the taker filled is followed by its status beat in
// the cycle after the trade beat is taken.
// The input is not ready while a request is being worked on.
// While the receiver holds ready low the pending result beat is held and
// the sequencer waits. Reset empties the table and clears the sequence
// counter at once; no clearing pass is needed.
module limit_order_book_matcher
  import lobm_pkg::*;
#(
  parameter int DEPTH      = 32,
  parameter int PRICE_BITS = 32,
  parameter int QTY_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [31:0] order_id_i,
  input  logic        side_i,
  input  logic [31:0] price_i,
  input  logic [31:0] quantity_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] trade_price_o,
  output logic [31:0] trade_quantity_o,
  output logic [31:0] resting_id_o,
  output logic [31:0] taker_id_o,
  output logic [31:0] left_quantity_o,
  output logic        last_o
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1) + 1;
  localparam int PW = PRICE_BITS;
  localparam int QW = QTY_BITS;

  // Table storage.
  logic [31:0]   mem_id    [DEPTH];
  logic          mem_side  [DEPTH];
  logic [PW-1:0] mem_price [DEPTH];
  logic [QW-1:0] mem_left  [DEPTH];
  logic [31:0]   mem_seq   [DEPTH];
  logic [DEPTH-1:0] valid_q, valid_d;

  state_e state_q, state_d;

  // Request registers.
  logic          kind_q, kind_d;
  logic [31:0]   tid_q, tid_d;
  logic          tside_q, tside_d;
  logic [PW-1:0] tprice_q, tprice_d;
  logic [QW-1:0] tleft_q, tleft_d;
  logic [31:0]   seq_q, seq_d;

  // Scan pipeline.
  logic [CW-1:0] addr_q, addr_d;
  logic          pend_q, pend_d;
  logic [IW-1:0] eidx_q, eidx_d;
  logic [31:0]   rd_id_q, rd_seq_q;
  logic          rd_side_q;
  logic [PW-1:0] rd_price_q;
  logic [QW-1:0] rd_left_q;

  // Scan results.
  logic          hit_q, hit_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d;
  logic [QW-1:0] hit_left_q, hit_left_d;
  logic          free_q, free_d;
  logic [IW-1:0] free_idx_q, free_idx_d;
  logic          best_q, best_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [PW-1:0] best_price_q, best_price_d;
  logic [QW-1:0] best_left_q, best_left_d;
  logic [31:0]   best_rid_q, best_rid_d;
  logic [31:0]   best_age_q, best_age_d;

  // Output register.
  logic          ovalid_q, ovalid_d;
  logic [2:0]    ost_q, ost_d;
  logic [PW-1:0] oprice_q, oprice_d;
  logic [QW-1:0] oqty_q, oqty_d;
  logic [31:0]   orid_q, orid_d;
  logic [QW-1:0] oleft_q, oleft_d;
  logic          olast_q, olast_d;

  // Table write port.
  logic          we_all, we_left;
  logic [IW-1:0] wr_idx;
  logic [QW-1:0] wr_left;

  logic [63:0]   price_ext, qty_ext;
  logic [31:0]   age;
  logic          crossing, better;
  logic [QW-1:0] fill_amt;
  logic          in_acc;

  assign price_ext = {32'd0, price_i};
  assign qty_ext   = {32'd0, quantity_i};
  assign age       = seq_q - rd_seq_q;
  assign in_acc    = in_valid_i && in_ready_o;
  assign fill_amt  = (tleft_q < best_left_q) ? tleft_q : best_left_q;

  always_comb begin
    crossing = (tside_q == SIDE_BUY) ? (rd_price_q <= tprice_q)
                                     : (rd_price_q >= tprice_q);
    if (!best_q) begin
      better = 1'b1;
    end else if (rd_price_q != best_price_q) begin
      better = (tside_q == SIDE_BUY) ? (rd_price_q < best_price_q)
                                     : (rd_price_q > best_price_q);
    end else begin
      better = age > best_age_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_all) begin
      mem_id[wr_idx]    <= tid_q;
      mem_side[wr_idx]  <= tside_q;
      mem_price[wr_idx] <= tprice_q;
      mem_seq[wr_idx]   <= seq_q;
    end
    if (we_all || we_left) begin
      mem_left[wr_idx] <= wr_left;
    end
    rd_id_q    <= mem_id[addr_q[IW-1:0]];
    rd_side_q  <= mem_side[addr_q[IW-1:0]];
    rd_price_q <= mem_price[addr_q[IW-1:0]];
    rd_left_q  <= mem_left[addr_q[IW-1:0]];
    rd_seq_q   <= mem_seq[addr_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= '0;
      seq_q    <= '0;
      ovalid_q <= 1'b0;
      pend_q   <= 1'b0;
      addr_q   <= '0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      seq_q    <= seq_d;
      ovalid_q <= ovalid_d;
      pend_q   <= pend_d;
      addr_q   <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    tid_q        <= tid_d;
    tside_q      <= tside_d;
    tprice_q     <= tprice_d;
    tleft_q      <= tleft_d;
    eidx_q       <= eidx_d;
    hit_q        <= hit_d;
    hit_idx_q    <= hit_idx_d;
    hit_left_q   <= hit_left_d;
    free_q       <= free_d;
    free_idx_q   <= free_idx_d;
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
    best_price_q <= best_price_d;
    best_left_q  <= best_left_d;
    best_rid_q   <= best_rid_d;
    best_age_q   <= best_age_d;
    ost_q        <= ost_d;
    oprice_q     <= oprice_d;
    oqty_q       <= oqty_d;
    orid_q       <= orid_d;
    oleft_q      <= oleft_d;
    olast_q      <= olast_d;
  end

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    seq_d   = seq_q;
    kind_d = kind_q; tid_d = tid_q; tside_d = tside_q;
    tprice_d = tprice_q; tleft_d = tleft_q;
    addr_d = addr_q; pend_d = 1'b0; eidx_d = eidx_q;
    hit_d = hit_q; hit_idx_d = hit_idx_q; hit_left_d = hit_left_q;
    free_d = free_q; free_idx_d = free_idx_q;
    best_d = best_q; best_idx_d = best_idx_q; best_price_d = best_price_q;
    best_left_d = best_left_q; best_rid_d = best_rid_q; best_age_d = best_age_q;
    ovalid_d = ovalid_q; ost_d = ost_q; oprice_d = oprice_q; oqty_d = oqty_q;
    orid_d = orid_q; oleft_d = oleft_q; olast_d = olast_q;
    we_all = 1'b0; we_left = 1'b0; wr_idx = best_idx_q; wr_left = best_left_q;
    in_ready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          kind_d   = kind_i;
          tid_d    = order_id_i;
          tside_d  = side_i;
          tprice_d = price_ext[PW-1:0];
          tleft_d  = qty_ext[QW-1:0];
          addr_d   = '0;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          best_d   = 1'b0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pend_q) begin
          if (valid_q[eidx_q]) begin
            if (rd_id_q == tid_q && !hit_q) begin
              hit_d = 1'b1; hit_idx_d = eidx_q; hit_left_d = rd_left_q;
            end
            if (rd_side_q != tside_q && crossing && better) begin
              best_d = 1'b1; best_idx_d = eidx_q; best_price_d = rd_price_q;
              best_left_d = rd_left_q; best_rid_d = rd_id_q; best_age_d = age;
            end
          end else if (!free_q) begin
            free_d = 1'b1; free_idx_d = eidx_q;
          end
        end
        if (addr_q < CW'(DEPTH)) begin
          pend_d = 1'b1;
          eidx_d = addr_q[IW-1:0];
          addr_d = addr_q + 1'b1;
        end else if (!pend_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ovalid_d = 1'b1;
        oprice_d = '0; oqty_d = '0; orid_d = '0; olast_d = 1'b1;
        oleft_d  = tleft_q;
        state_d  = ST_OUT;
        if (kind_q == KIND_CANCEL) begin
          if (hit_q) begin
            valid_d[hit_idx_q] = 1'b0;
            ost_d   = STS_CANCELLED;
            oleft_d = hit_left_q;
          end else begin
            ost_d   = STS_NOT_FOUND;
            oleft_d = '0;
          end
        end else if (hit_q) begin
          ost_d = STS_DUPLICATE;
        end else if (tleft_q == '0) begin
          ost_d = STS_DONE;
        end else if (best_q) begin
          // One fill against the best resting order.
          we_left  = 1'b1;
          wr_left  = best_left_q - fill_amt;
          if (best_left_q == fill_amt) valid_d[best_idx_q] = 1'b0;
          tleft_d  = tleft_q - fill_amt;
          ost_d    = STS_TRADE;
          oprice_d = best_price_q;
          oqty_d   = fill_amt;
          orid_d   = best_rid_q;
          oleft_d  = tleft_q - fill_amt;
          olast_d  = 1'b0;
        end else if (free_q) begin
          we_all  = 1'b1;
          wr_idx  = free_idx_q;
          wr_left = tleft_q;
          valid_d[free_idx_q] = 1'b1;
          seq_d   = seq_q + 1'b1;
          ost_d   = STS_RESTED;
        end else begin
          ost_d = STS_FULL;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          ovalid_d = 1'b0;
          if (olast_q) begin
            state_d = ST_IDLE;
          end else if (tleft_q == '0) begin
            // Taker filled: the status beat follows straight away.
            ovalid_d = 1'b1;
            ost_d    = STS_DONE;
            oprice_d = '0; oqty_d = '0; orid_d = '0; oleft_d = '0;
            olast_d  = 1'b1;
          end else begin
            addr_d  = '0;
            hit_d   = 1'b0;
            free_d  = 1'b0;
            best_d  = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  logic [63:0] oprice_ext, oqty_ext, oleft_ext;
  assign oprice_ext = 64'(oprice_q);
  assign oqty_ext   = 64'(oqty_q);
  assign oleft_ext  = 64'(oleft_q);

  assign out_valid_o      = ovalid_q;
  assign status_o         = ost_q;
  assign trade_price_o    = oprice_ext[31:0];
  assign trade_quantity_o = oqty_ext[31:0];
  assign resting_id_o     = orid_q;
  assign taker_id_o       = tid_q;
  assign left_quantity_o  = oleft_ext[31:0];
  assign last_o           = olast_q;

`include "assert_macros.svh"

  `ASSERT_IMP(a_idle_no_result, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `ASSERT_IMP(a_not_last_is_trade, clk_i, rst_ni, out_valid_o && !last_o, status_o == STS_TRADE)
  `ASSERT_NEXT(a_accept_scans, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ST_SCAN)

endmodule
